// ===== design/tes_pkg.sv =====
// Shared types, constants and codes of the timestamped event scheduler.
package tes_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 24;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   localparam int TYPE_BITS   = 2;
   localparam int START_BITS  = 24;
   localparam int WORD_BITS   = 32;
   localparam int LENGTH_BITS = 13;

   localparam int CMD_DEPTH   = 2;
   localparam int CMD_PTR_BITS  = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_FILL_BITS = $clog2(CMD_DEPTH + 1);

   localparam logic [31:0] TIME_MAX = 32'((64'd1 << TIME_BITS) - 64'd1);

   localparam logic KIND_PUSH  = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   localparam logic [TYPE_BITS-1:0] EV_NOTE_ON   = 2'd0;
   localparam logic [TYPE_BITS-1:0] EV_NOTE_OFF  = 2'd1;
   localparam logic [TYPE_BITS-1:0] EV_SET_PARAM = 2'd2;

   typedef struct packed {
      logic                   is_block;
      logic [TYPE_BITS-1:0]   ev_type;
      logic [TIME_BITS-1:0]   delay;
      logic [WORD_BITS-1:0]   word_a;
      logic [WORD_BITS-1:0]   word_b;
      logic [LENGTH_BITS-1:0] length;
   } cmd_type;

endpackage

// ===== design/tes_channels.sv =====
// Request and response channel interfaces of the event scheduler.
interface tes_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [tes_pkg::TYPE_BITS-1:0]   event_type;
   logic [tes_pkg::START_BITS-1:0]  start_time;
   logic [tes_pkg::WORD_BITS-1:0]   payload_a;
   logic [tes_pkg::WORD_BITS-1:0]   payload_b;
   logic [tes_pkg::LENGTH_BITS-1:0] block_length;

   modport source (output valid, kind, event_type, start_time, payload_a, payload_b,
                   block_length, input ready);
   modport sink (input valid, kind, event_type, start_time, payload_a, payload_b,
                 block_length, output ready);
endinterface

interface tes_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tes_pkg::LENGTH_BITS-1:0] samples_before;
   logic                            has_event;
   logic [tes_pkg::TYPE_BITS-1:0]   out_type;
   logic [tes_pkg::WORD_BITS-1:0]   out_payload_a;
   logic [tes_pkg::WORD_BITS-1:0]   out_payload_b;
   logic                            dropped;
   logic                            last;

   modport source (output valid, samples_before, has_event, out_type, out_payload_a,
                   out_payload_b, dropped, last, input ready);
   modport sink (input valid, samples_before, has_event, out_type, out_payload_a,
                 out_payload_b, dropped, last, output ready);
endinterface

// ===== design/timestamped_event_scheduler.sv =====
// Top level of the timestamped event scheduler: front end, command queue and event store.
//
// A push beat yields one response beat; a block beat runs in the event store as a start step,
// then one response beat per event due in the block as the head entry leaves the sorted store,
// then a closing beat. Requests pass a two-entry command queue, which registers them, and are
// taken while the store is busy until the queue fills.
// Responses leave from a register and the store stalls only while that register is held.
// Store contents need no clearing after reset; the block is ready in the first cycle after it.
module timestamped_event_scheduler (
   input  logic     clock,
   input  logic     reset,
   tes_req_if.sink  req_if,
   tes_rsp_if.source rsp_if
);

   logic             cmd_valid;
   logic             cmd_ready;
   tes_pkg::cmd_type cmd;

   tes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   tes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_if    (rsp_if)
   );

endmodule

// ===== design/tes_front.sv =====
// Front end: takes request beats, decodes them into commands and queues them.
module tes_front (
   input  logic             clock,
   input  logic             reset,
   tes_req_if.sink          req_if,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output tes_pkg::cmd_type cmd
);

   tes_pkg::cmd_type                    slot_ff [tes_pkg::CMD_DEPTH];
   logic [tes_pkg::CMD_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [tes_pkg::CMD_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [tes_pkg::CMD_FILL_BITS-1:0]   fill_ff, fill_in;
   tes_pkg::cmd_type                    decoded;
   logic [31:0]                         start_wide;
   logic                                push_beat;
   logic                                pop_beat;

   // saturate the delay to the stored time range
   always_comb begin
      start_wide = 32'(req_if.start_time);
      if (start_wide > tes_pkg::TIME_MAX) begin
         start_wide = tes_pkg::TIME_MAX;
      end
      decoded.is_block = (req_if.kind == tes_pkg::KIND_BLOCK);
      decoded.ev_type  = req_if.event_type;
      decoded.delay    = start_wide[tes_pkg::TIME_BITS-1:0];
      decoded.word_a   = req_if.payload_a;
      decoded.word_b   = req_if.payload_b;
      decoded.length   = req_if.block_length;
   end

   assign req_if.ready = (fill_ff != tes_pkg::CMD_FILL_BITS'(tes_pkg::CMD_DEPTH));
   assign push_beat    = req_if.valid && req_if.ready;
   assign cmd_valid    = (fill_ff != '0);
   assign pop_beat     = cmd_valid && cmd_ready;
   assign cmd          = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_beat) begin
         wr_ptr_in = (wr_ptr_ff == tes_pkg::CMD_PTR_BITS'(tes_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_beat) begin
         rd_ptr_in = (rd_ptr_ff == tes_pkg::CMD_PTR_BITS'(tes_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push_beat && !pop_beat) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push_beat && pop_beat) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_beat) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= tes_pkg::CMD_FILL_BITS'(tes_pkg::CMD_DEPTH))
      else $error("command queue overfilled");

   a_fill_grows: assert property (@(posedge clock) disable iff (reset)
      (push_beat && !pop_beat) |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("command queue lost a beat");

endmodule

// ===== design/tes_back.sv =====
// Back end: sorted event store, block sequencer and response register.
module tes_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  tes_pkg::cmd_type cmd,
   tes_rsp_if.source        rsp_if
);

   localparam logic [0:0] ST_IDLE  = 1'b0;
   localparam logic [0:0] ST_BLOCK = 1'b1;

   logic [tes_pkg::TIME_BITS-1:0]   delay_ff [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::TIME_BITS-1:0]   delay_in [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::TYPE_BITS-1:0]   kind_ff  [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::TYPE_BITS-1:0]   kind_in  [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::WORD_BITS-1:0]   word_a_ff [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::WORD_BITS-1:0]   word_a_in [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::WORD_BITS-1:0]   word_b_ff [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::WORD_BITS-1:0]   word_b_in [tes_pkg::QUEUE_DEPTH];
   logic [tes_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic [0:0]                      state_ff, state_in;
   logic [tes_pkg::LENGTH_BITS-1:0] n_ff, n_in;
   logic [tes_pkg::LENGTH_BITS-1:0] at_ff, at_in;

   logic                            out_valid_ff, out_valid_in;
   logic [tes_pkg::LENGTH_BITS-1:0] out_before_ff, out_before_in;
   logic                            out_has_ff, out_has_in;
   logic [tes_pkg::TYPE_BITS-1:0]   out_type_ff, out_type_in;
   logic [tes_pkg::WORD_BITS-1:0]   out_a_ff, out_a_in;
   logic [tes_pkg::WORD_BITS-1:0]   out_b_ff, out_b_in;
   logic                            out_dropped_ff, out_dropped_in;
   logic                            out_last_ff, out_last_in;

   logic [tes_pkg::QUEUE_DEPTH-1:0] gt;
   logic [tes_pkg::QUEUE_DEPTH-1:0] prev_gt;
   logic                            out_free;
   logic                            head_due;
   logic                            head_known;
   logic [tes_pkg::LENGTH_BITS-1:0] head_time;

   assign out_free   = !out_valid_ff || rsp_if.ready;
   assign head_due   = (count_ff != '0) && (32'(delay_ff[0]) < 32'(n_ff));
   assign head_time  = tes_pkg::LENGTH_BITS'(32'(delay_ff[0]));
   assign head_known = (kind_ff[0] == tes_pkg::EV_NOTE_ON) ||
                       (kind_ff[0] == tes_pkg::EV_NOTE_OFF) ||
                       (kind_ff[0] == tes_pkg::EV_SET_PARAM);

   // empty slots count as later than anything, so gt is a thermometer code
   always_comb begin
      for (int i = 0; i < tes_pkg::QUEUE_DEPTH; i++) begin
         gt[i] = (tes_pkg::COUNT_BITS'(i) >= count_ff) || (delay_ff[i] > cmd.delay);
      end
      prev_gt[0] = 1'b0;
      for (int i = 1; i < tes_pkg::QUEUE_DEPTH; i++) begin
         prev_gt[i] = gt[i-1];
      end
   end

   always_comb begin
      delay_in       = delay_ff;
      kind_in        = kind_ff;
      word_a_in      = word_a_ff;
      word_b_in      = word_b_ff;
      count_in       = count_ff;
      state_in       = state_ff;
      n_in           = n_ff;
      at_in          = at_ff;
      cmd_ready      = 1'b0;
      out_valid_in   = out_valid_ff && !rsp_if.ready;
      out_before_in  = out_before_ff;
      out_has_in     = out_has_ff;
      out_type_in    = out_type_ff;
      out_a_in       = out_a_ff;
      out_b_in       = out_b_ff;
      out_dropped_in = out_dropped_ff;
      out_last_in    = out_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               if (cmd.is_block) begin
                  n_in     = cmd.length;
                  at_in    = '0;
                  state_in = ST_BLOCK;
               end else begin
                  out_valid_in   = 1'b1;
                  out_before_in  = '0;
                  out_has_in     = 1'b0;
                  out_type_in    = '0;
                  out_a_in       = '0;
                  out_b_in       = '0;
                  out_last_in    = 1'b1;
                  out_dropped_in = (count_ff == tes_pkg::COUNT_BITS'(tes_pkg::QUEUE_DEPTH));
                  if (!out_dropped_in) begin
                     count_in = count_ff + 1'b1;
                     // entries behind the insert point move up one slot
                     for (int i = 1; i < tes_pkg::QUEUE_DEPTH; i++) begin
                        if (gt[i] && prev_gt[i]) begin
                           delay_in[i]  = delay_ff[i-1];
                           kind_in[i]   = kind_ff[i-1];
                           word_a_in[i] = word_a_ff[i-1];
                           word_b_in[i] = word_b_ff[i-1];
                        end
                     end
                     for (int i = 0; i < tes_pkg::QUEUE_DEPTH; i++) begin
                        if (gt[i] && !prev_gt[i]) begin
                           delay_in[i]  = cmd.delay;
                           kind_in[i]   = cmd.ev_type;
                           word_a_in[i] = cmd.word_a;
                           word_b_in[i] = cmd.word_b;
                        end
                     end
                  end
               end
            end
         end
         ST_BLOCK: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_dropped_in = 1'b0;
               if (head_due) begin
                  out_before_in = head_time - at_ff;
                  out_has_in    = head_known;
                  out_type_in   = head_known ? kind_ff[0] : '0;
                  out_a_in      = head_known ? word_a_ff[0] : '0;
                  out_b_in      = head_known ? word_b_ff[0] : '0;
                  out_last_in   = 1'b0;
                  at_in         = head_time;
                  count_in      = count_ff - 1'b1;
                  for (int i = 0; i < tes_pkg::QUEUE_DEPTH - 1; i++) begin
                     delay_in[i]  = delay_ff[i+1];
                     kind_in[i]   = kind_ff[i+1];
                     word_a_in[i] = word_a_ff[i+1];
                     word_b_in[i] = word_b_ff[i+1];
                  end
               end else begin
                  out_before_in = n_ff - at_ff;
                  out_has_in    = 1'b0;
                  out_type_in   = '0;
                  out_a_in      = '0;
                  out_b_in      = '0;
                  out_last_in   = 1'b1;
                  state_in      = ST_IDLE;
                  // every remaining entry is at or past block end
                  for (int i = 0; i < tes_pkg::QUEUE_DEPTH; i++) begin
                     delay_in[i] = tes_pkg::TIME_BITS'(32'(delay_ff[i]) - 32'(n_ff));
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff       <= delay_in;
      kind_ff        <= kind_in;
      word_a_ff      <= word_a_in;
      word_b_ff      <= word_b_in;
      n_ff           <= n_in;
      at_ff          <= at_in;
      out_before_ff  <= out_before_in;
      out_has_ff     <= out_has_in;
      out_type_ff    <= out_type_in;
      out_a_ff       <= out_a_in;
      out_b_ff       <= out_b_in;
      out_dropped_ff <= out_dropped_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.samples_before = out_before_ff;
   assign rsp_if.has_event      = out_has_ff;
   assign rsp_if.out_type       = out_type_ff;
   assign rsp_if.out_payload_a  = out_a_ff;
   assign rsp_if.out_payload_b  = out_b_ff;
   assign rsp_if.dropped        = out_dropped_ff;
   assign rsp_if.last           = out_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tes_pkg::COUNT_BITS'(tes_pkg::QUEUE_DEPTH))
      else $error("event count beyond store depth");

   a_drop_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_dropped_ff) |-> (out_last_ff && !out_has_ff))
      else $error("drop flag on a non-push beat");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= tes_pkg::COUNT_BITS'(2)) |-> (delay_ff[0] <= delay_ff[1]))
      else $error("event store out of order");

   a_dispatch_pops: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLOCK && out_free && head_due) |=>
      count_ff == $past(count_ff) - 1'b1)
      else $error("dispatched event not removed");

endmodule

// ===== dv/tes_dispatch_checker.sv =====
`timescale 1ns / 100ps
// Scheduler checker: mirrors the event store, predicts response beats and compares them.
module tes_dispatch_checker
   import tes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tes_req_if   req_if,
   tes_rsp_if   rsp_if,
   output int   fail_count,
   output int   beats_outstanding
);

   typedef struct packed {
      logic [LENGTH_BITS-1:0] samples_before;
      logic                   has_event;
      logic [TYPE_BITS-1:0]   out_type;
      logic [WORD_BITS-1:0]   payload_a;
      logic [WORD_BITS-1:0]   payload_b;
      logic                   dropped;
      logic                   last;
   } dispatch_beat_type;

   logic [TIME_BITS-1:0] store_delay  [QUEUE_DEPTH];
   logic [TYPE_BITS-1:0] store_type   [QUEUE_DEPTH];
   logic [WORD_BITS-1:0] store_word_a [QUEUE_DEPTH];
   logic [WORD_BITS-1:0] store_word_b [QUEUE_DEPTH];
   int                   store_count;
   dispatch_beat_type    awaited_dispatches[$];

   initial begin
      fail_count        = 0;
      beats_outstanding = 0;
      store_count       = 0;
   end

   task automatic report_mismatch(input string note);
      $display("%0t ns: mismatch: %s", $time, note);
      fail_count++;
   endtask

   // Sorted insert after all equal delays; a full store loses the event.
   function automatic void insert_event(input logic [TYPE_BITS-1:0] kind_in,
                                        input logic [START_BITS-1:0] start,
                                        input logic [WORD_BITS-1:0] word_a,
                                        input logic [WORD_BITS-1:0] word_b);
      logic [TIME_BITS-1:0] delay;
      int                   pos;
      dispatch_beat_type    beat;
      beat      = '0;
      beat.last = 1'b1;
      if (store_count >= QUEUE_DEPTH) begin
         beat.dropped = 1'b1;
         awaited_dispatches.push_back(beat);
         return;
      end
      if (32'(start) > TIME_MAX)
         delay = TIME_BITS'(TIME_MAX);
      else
         delay = TIME_BITS'(start);
      pos = 0;
      while (pos < store_count && store_delay[pos] <= delay)
         pos++;
      for (int i = store_count; i > pos; i--) begin
         store_delay[i]  = store_delay[i-1];
         store_type[i]   = store_type[i-1];
         store_word_a[i] = store_word_a[i-1];
         store_word_b[i] = store_word_b[i-1];
      end
      store_delay[pos]  = delay;
      store_type[pos]   = kind_in;
      store_word_a[pos] = word_a;
      store_word_b[pos] = word_b;
      store_count++;
      awaited_dispatches.push_back(beat);
   endfunction

   // Dispatch everything due within the block, then the closing beat; age the rest.
   function automatic void render_block(input logic [LENGTH_BITS-1:0] length);
      logic [LENGTH_BITS-1:0] cursor;
      logic [TYPE_BITS-1:0]   t;
      logic                   known;
      int                     due;
      dispatch_beat_type      beat;
      cursor = '0;
      due    = 0;
      while (due < store_count && 32'(store_delay[due]) < 32'(length)) begin
         t     = store_type[due];
         known = (t == EV_NOTE_ON) || (t == EV_NOTE_OFF) || (t == EV_SET_PARAM);
         beat  = '0;
         beat.samples_before = LENGTH_BITS'(store_delay[due]) - cursor;
         if (known) begin
            beat.has_event = 1'b1;
            beat.out_type  = t;
            beat.payload_a = store_word_a[due];
            beat.payload_b = store_word_b[due];
         end
         awaited_dispatches.push_back(beat);
         cursor = LENGTH_BITS'(store_delay[due]);
         due++;
      end
      beat                = '0;
      beat.samples_before = length - cursor;
      beat.last           = 1'b1;
      awaited_dispatches.push_back(beat);
      for (int i = due; i < store_count; i++) begin
         store_delay[i-due]  = store_delay[i] - TIME_BITS'(length);
         store_type[i-due]   = store_type[i];
         store_word_a[i-due] = store_word_a[i];
         store_word_b[i-due] = store_word_b[i];
      end
      store_count -= due;
   endfunction

   always @(posedge clock) begin
      dispatch_beat_type got;
      dispatch_beat_type want;
      if (reset) begin
         store_count = 0;
         awaited_dispatches.delete();
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.kind == KIND_PUSH)
               insert_event(req_if.event_type, req_if.start_time, req_if.payload_a,
                            req_if.payload_b);
            else
               render_block(req_if.block_length);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got = '{rsp_if.samples_before, rsp_if.has_event, rsp_if.out_type,
                    rsp_if.out_payload_a, rsp_if.out_payload_b, rsp_if.dropped, rsp_if.last};
            if (awaited_dispatches.size() == 0) begin
               report_mismatch($sformatf("response beat with nothing pending: %p", got));
            end else begin
               want = awaited_dispatches.pop_front();
               if (got.samples_before !== want.samples_before)
                  report_mismatch($sformatf("samples_before got %0d want %0d",
                                            got.samples_before, want.samples_before));
               if (got.has_event !== want.has_event)
                  report_mismatch($sformatf("has_event got %0b want %0b",
                                            got.has_event, want.has_event));
               if (got.out_type !== want.out_type)
                  report_mismatch($sformatf("out_type got %0d want %0d",
                                            got.out_type, want.out_type));
               if (got.payload_a !== want.payload_a)
                  report_mismatch($sformatf("out_payload_a got 0x%0h want 0x%0h",
                                            got.payload_a, want.payload_a));
               if (got.payload_b !== want.payload_b)
                  report_mismatch($sformatf("out_payload_b got 0x%0h want 0x%0h",
                                            got.payload_b, want.payload_b));
               if (got.dropped !== want.dropped)
                  report_mismatch($sformatf("dropped got %0b want %0b",
                                            got.dropped, want.dropped));
               if (got.last !== want.last)
                  report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
            end
         end
      end
      beats_outstanding = awaited_dispatches.size();
   end

endmodule

// ===== dv/tb_timestamped_event_scheduler.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus and response stalls for the event scheduler.
module tb_timestamped_event_scheduler;
   import tes_pkg::*;

   localparam logic [TYPE_BITS-1:0] EV_UNKNOWN = 2'd3;
   localparam int ITEM_TARGET  = 330;
   localparam int BUSY_PCT     = 35;
   localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   req_idle_pct  = BUSY_PCT;
   int   rsp_stall_pct = BUSY_PCT;
   int   items_sent    = 0;
   int   mismatch_total;
   int   beats_outstanding;
   logic [START_BITS-1:0] last_delay = '0;

   tes_req_if req_ch ();
   tes_rsp_if rsp_ch ();

   timestamped_event_scheduler dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   tes_dispatch_checker dispatch_chk (
      .clock             (clock),
      .reset             (reset),
      .req_if            (req_ch),
      .rsp_if            (rsp_ch),
      .fail_count        (mismatch_total),
      .beats_outstanding (beats_outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Holds one request beat until it is taken; idles before it at random.
   task automatic send_beat(input logic kind, input logic [TYPE_BITS-1:0] ev,
                            input logic [START_BITS-1:0] start,
                            input logic [WORD_BITS-1:0] word_a,
                            input logic [WORD_BITS-1:0] word_b,
                            input logic [LENGTH_BITS-1:0] length);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.event_type   <= ev;
      req_ch.start_time   <= start;
      req_ch.payload_a    <= word_a;
      req_ch.payload_b    <= word_b;
      req_ch.block_length <= length;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   // block_length is don't-care on a push, so it carries junk
   task automatic push_event(input logic [TYPE_BITS-1:0] ev, input logic [START_BITS-1:0] start,
                             input logic [WORD_BITS-1:0] word_a,
                             input logic [WORD_BITS-1:0] word_b);
      send_beat(KIND_PUSH, ev, start, word_a, word_b, LENGTH_BITS'($urandom));
      last_delay = start;
   endtask

   task automatic run_block(input logic [LENGTH_BITS-1:0] length);
      send_beat(KIND_BLOCK, TYPE_BITS'($urandom), START_BITS'($urandom), $urandom, $urandom,
                length);
   endtask

   initial begin
      logic [LENGTH_BITS-1:0] len;
      logic [START_BITS-1:0]  start;
      logic [TYPE_BITS-1:0]   ev;
      int                     pick;
      int                     burst;
      int                     idle;
      bit                     wide_delays;

      req_ch.valid        = 1'b0;
      req_ch.kind         = KIND_PUSH;
      req_ch.event_type   = EV_NOTE_ON;
      req_ch.start_time   = '0;
      req_ch.payload_a    = '0;
      req_ch.payload_b    = '0;
      req_ch.block_length = '0;
      rsp_ch.ready        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty store, zero-length blocks, ties, unknown type, full store
      run_block(0);
      run_block(1);
      push_event(EV_NOTE_ON, '0, '1, '1);
      push_event(EV_NOTE_OFF, 5, $urandom, '0);
      push_event(EV_SET_PARAM, 5, $urandom, $urandom);
      push_event(EV_UNKNOWN, 3, $urandom, $urandom);
      run_block(0);
      run_block(8);
      for (int k = 0; k < QUEUE_DEPTH; k++)
         push_event(TYPE_BITS'(k % 3), START_BITS'((k / 2) * 250), $urandom, $urandom);
      push_event(EV_NOTE_ON, 10, $urandom, $urandom);
      run_block(4096);

      // random: bursts of pushes closed by a block; wide delays only near the end,
      // since they would sit in the store for the rest of the run
      while (items_sent < ITEM_TARGET) begin
         idle          = (items_sent >= 120 && items_sent < 190) ? 0 : BUSY_PCT;
         req_idle_pct  = idle;
         rsp_stall_pct = idle;
         wide_delays   = (items_sent >= ITEM_TARGET - 40);
         pick = $urandom_range(99);
         if (pick < 5)
            len = 0;
         else if (pick < 12)
            len = 4096;
         else if (pick < 15)
            len = LENGTH_BITS'($urandom_range(8191, 4097));
         else if (pick < 25)
            len = 1;
         else
            len = LENGTH_BITS'($urandom_range(600, 2));
         burst = ($urandom_range(3) == 0) ? $urandom_range(18, 12) : $urandom_range(6, 0);
         repeat (burst) begin
            pick = $urandom_range(99);
            if (wide_delays && pick < 30) begin
               start = START_BITS'($urandom);
            end else if (pick < 50) begin
               start = START_BITS'($urandom_range(len + len / 2, 0));
            end else if (pick < 65) begin
               start = last_delay;
            end else if (pick < 75) begin
               // right at the block edge
               start = START_BITS'(len);
               if (len != 0 && $urandom_range(1) == 1)
                  start = start - 1'b1;
            end else begin
               start = START_BITS'($urandom_range(3 * len + 100, 0));
            end
            ev = ($urandom_range(9) == 0) ? EV_UNKNOWN : TYPE_BITS'($urandom_range(2));
            push_event(ev, start, $urandom, $urandom);
         end
         run_block(len);
      end
      push_event(EV_SET_PARAM, '1, '0, '0);
      run_block('1);

      req_ch.valid <= 1'b0;
      while (beats_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_total == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
